// ----- src/hmrp_pkg.sv -----
// Shared constants, types and method decode functions for the request line parser
`timescale 1ns / 1ps

package hmrp_pkg;

	// longest buffer searched, bytes beyond it are ignored
	localparam int MAX_LEN = 4096;
	// shortest buffer that may carry a recognized method
	localparam int MIN_LEN = 16;

	localparam int POS_W   = $clog2(MAX_LEN + 1);
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int ROUTE_W = 13;
	localparam int METH_W  = 3;
	localparam int BEGIN_W = 4;
	localparam int OUT_W   = 24;

	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_NUL   = 8'h00;

	// first four bytes, first byte in the top bits
	localparam logic [31:0] PFX_GET  = 32'h47455420;
	localparam logic [31:0] PFX_POST = 32'h504F5354;
	localparam logic [31:0] PFX_PUT  = 32'h50555420;
	localparam logic [31:0] PFX_PATC = 32'h50415443;
	localparam logic [31:0] PFX_DELE = 32'h44454C45;
	localparam logic [31:0] PFX_OPTI = 32'h4F505449;

	typedef enum logic [METH_W-1:0] {
		METH_NONE    = 3'd0,
		METH_GET     = 3'd1,
		METH_POST    = 3'd2,
		METH_PUT     = 3'd3,
		METH_PATCH   = 3'd4,
		METH_DELETE  = 3'd5,
		METH_OPTIONS = 3'd6
	} method_t;

	// one parse result
	typedef struct packed {
		logic               too_long;
		logic               route_found;
		logic [ROUTE_W-1:0] route_last;
		logic [BEGIN_W-1:0] route_begin;
		method_t            method_code;
	} result_t;

	// input stage control toward the scan core
	typedef struct packed {
		logic       valid;
		logic       step;
		logic       last;
		logic [7:0] data;
	} stage_t;

	function automatic method_t method_of_prefix(input logic [31:0] p);
		method_t m;
		unique case (p)
			PFX_GET:  m = METH_GET;
			PFX_POST: m = METH_POST;
			PFX_PUT:  m = METH_PUT;
			PFX_PATC: m = METH_PATCH;
			PFX_DELE: m = METH_DELETE;
			PFX_OPTI: m = METH_OPTIONS;
			default:  m = METH_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [BEGIN_W-1:0] start_of_method(input method_t m);
		logic [BEGIN_W-1:0] s;
		unique case (m)
			METH_GET:     s = 4'd4;
			METH_POST:    s = 4'd5;
			METH_PUT:     s = 4'd4;
			METH_PATCH:   s = 4'd6;
			METH_DELETE:  s = 4'd7;
			METH_OPTIONS: s = 4'd8;
			default:      s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

// ----- src/hmrp_in_stage.sv -----
// Input register stage with stall control toward the result register
`timescale 1ns / 1ps

module hmrp_in_stage
	import hmrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // data_byte [7:0]
	input  logic       s_tlast,
	input  logic       out_free,
	output stage_t     stage
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] data_s1;
	logic       step;

	// a non-final byte never needs the result register
	assign step     = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || step;

	// control part of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload part of the stage
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign stage = '{valid: valid_s1, step: step, last: last_s1, data: data_s1};

endmodule

// ----- src/hmrp_scan.sv -----
// Per-byte prefix capture, space search and result formation
`timescale 1ns / 1ps

module hmrp_scan
	import hmrp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  stage_t  stage,
	output result_t res
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic             ovf_q, ovf_d;
	logic [23:0]      prefix_q, prefix_d;
	method_t          cand_q, cand_d;
	logic [IDX_W-1:0] zpos_q, zpos_d;
	logic             zfound_q, zfound_d, zdone_q, zdone_d;
	logic [IDX_W-1:0] spos_q, spos_d;
	logic             sfound_q, sfound_d, sdone_q, sdone_d;

	logic               in_range;
	logic               is_space;
	logic               is_nul;
	logic [BEGIN_W-1:0] cand_start;
	logic               use_start;
	logic               found;
	logic [IDX_W-1:0]   pos_sel;

	assign in_range   = pos_q < POS_W'(MAX_LEN);
	assign is_space   = stage.data == CHR_SPACE;
	assign is_nul     = stage.data == CHR_NUL;
	assign cand_start = start_of_method(cand_q);

	// next state for the current byte
	always_comb begin
		pos_d    = pos_q;
		ovf_d    = ovf_q;
		prefix_d = prefix_q;
		cand_d   = cand_q;
		zpos_d   = zpos_q;
		zfound_d = zfound_q;
		zdone_d  = zdone_q;
		spos_d   = spos_q;
		sfound_d = sfound_q;
		sdone_d  = sdone_q;
		if (in_range) begin
			pos_d = pos_q + POS_W'(1);
			if (pos_q < POS_W'(4)) begin
				prefix_d = {prefix_q[15:0], stage.data};
				if (pos_q == POS_W'(3)) begin
					cand_d = method_of_prefix({prefix_q, stage.data});
				end
			end
			// search from offset zero
			if (!zdone_q && (is_nul || is_space)) begin
				zdone_d  = 1'b1;
				zfound_d = is_space;
				zpos_d   = pos_q[IDX_W-1:0];
			end
			// search from the method's route offset
			if (cand_q != METH_NONE && pos_q >= POS_W'(cand_start) && !sdone_q
				&& (is_nul || is_space)) begin
				sdone_d  = 1'b1;
				sfound_d = is_space;
				spos_d   = pos_q[IDX_W-1:0];
			end
		end else begin
			ovf_d = 1'b1;
		end
	end

	// result from the updated state
	always_comb begin
		use_start       = (pos_d >= POS_W'(MIN_LEN)) && (cand_d != METH_NONE);
		found           = use_start ? sfound_d : zfound_d;
		pos_sel         = use_start ? spos_d : zpos_d;
		res.method_code = (use_start && found) ? cand_d : METH_NONE;
		res.route_begin = use_start ? start_of_method(cand_d) : '0;
		res.route_last  = found ? (ROUTE_W'(pos_sel) - ROUTE_W'(1)) : '0;
		res.route_found = found;
		res.too_long    = ovf_d;
	end

	// state registers, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ovf_q    <= 1'b0;
			prefix_q <= '0;
			cand_q   <= METH_NONE;
			zpos_q   <= '0;
			zfound_q <= 1'b0;
			zdone_q  <= 1'b0;
			spos_q   <= '0;
			sfound_q <= 1'b0;
			sdone_q  <= 1'b0;
		end else if (stage.step) begin
			if (stage.last) begin
				pos_q    <= '0;
				ovf_q    <= 1'b0;
				prefix_q <= '0;
				cand_q   <= METH_NONE;
				zpos_q   <= '0;
				zfound_q <= 1'b0;
				zdone_q  <= 1'b0;
				spos_q   <= '0;
				sfound_q <= 1'b0;
				sdone_q  <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				ovf_q    <= ovf_d;
				prefix_q <= prefix_d;
				cand_q   <= cand_d;
				zpos_q   <= zpos_d;
				zfound_q <= zfound_d;
				zdone_q  <= zdone_d;
				spos_q   <= spos_d;
				sfound_q <= sfound_d;
				sdone_q  <= sdone_d;
			end
		end
	end

endmodule

// ----- src/http_method_route_parser.sv -----
// Top level of the request line method and route parser
`timescale 1ns / 1ps

// Takes one request byte per cycle (tlast on the final byte of a buffer) and
// gives one request on the master side per buffer, at its final byte: the
// method code, the offset where the route search began, the position of the
// first space minus one, a found flag and an overlong flag. Bytes are taken
// back to back at one per cycle; a result passes through the input register
// and then the result register after its final byte is accepted. A
// result waiting on m_tready stalls the input only when another final byte
// reaches the input register. Bytes at positions of MAX_LEN and beyond are
// not searched.
module http_method_route_parser
	import hmrp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // data_byte [7:0]
	input  logic             s_tlast,  // is_last
	output logic             m_tvalid,
	input  logic             m_tready,
	// method_code [2:0], route_begin [6:3], route_last [19:7],
	// route_found [20], too_long [21], zero [23:22]
	output logic [OUT_W-1:0] m_tdata
);

	stage_t  stage;
	result_t res;
	logic    out_free;
	logic    load;
	logic    out_valid_q;
	result_t out_q;

	assign out_free = !out_valid_q || m_tready;
	assign load     = stage.step && stage.last;

	hmrp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.out_free (out_free),
		.stage    (stage)
	);

	hmrp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.stage  (stage),
		.res    (res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_q};

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && out_valid_q && !m_tready))
		else $error("result overwritten while held");

	// an empty input register always takes a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!stage.valid |-> s_tready)
		else $error("input stalled while empty");

	// no space means no method and no route end
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.route_found |->
		(out_q.method_code == METH_NONE) && (out_q.route_last == '0))
		else $error("route fields set without a space");

	// a recognized method always has a nonzero route start
	a_begin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.method_code != METH_NONE) |-> (out_q.route_begin != '0))
		else $error("method without route start");

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for the request line method and route parser
`timescale 1ns / 1ps

module tb;
	import hmrp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_BYTES   = 1000;
	localparam int REPORT_LIMIT   = 10;

	// route search start offset per method code
	localparam logic [BEGIN_W-1:0] ROUTE_OFS [0:6] =
		'{4'd0, 4'd4, 4'd5, 4'd4, 4'd6, 4'd7, 4'd8};

	typedef logic [7:0] octet_q_t[$];

	// progress of one search for the first space
	typedef struct {
		bit               found;
		bit               done;
		logic [POS_W-1:0] at;
	} space_scan_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;   // data_byte [7:0]
	logic             s_tlast = 1'b0; // is_last
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	// method_code [2:0], route_begin [6:3], route_last [19:7],
	// route_found [20], too_long [21], zero [23:22]
	logic [OUT_W-1:0] m_tdata;

	// predictor state
	logic [POS_W-1:0] seen_cnt;
	bit               seen_over;
	logic [31:0]      head_word;
	method_t          head_method;
	space_scan_t      scan_any;
	space_scan_t      scan_route;
	result_t          expected_routes[$];

	int mismatches = 0;
	bit steady     = 1'b0;
	bit hold_req   = 1'b0;
	bit hold_active = 1'b0;

	http_method_route_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// decode of the first four bytes
	function automatic method_t decode_head(input logic [31:0] w);
		case (w)
			PFX_GET:  return METH_GET;
			PFX_POST: return METH_POST;
			PFX_PUT:  return METH_PUT;
			PFX_PATC: return METH_PATCH;
			PFX_DELE: return METH_DELETE;
			PFX_OPTI: return METH_OPTIONS;
			default:  return METH_NONE;
		endcase
	endfunction

	// one byte of a space search, a nul ends it without a hit
	function automatic space_scan_t scan_step(input space_scan_t s, input logic [7:0] b,
			input logic [POS_W-1:0] p);
		space_scan_t n;
		n = s;
		if (!n.done) begin
			if (b == CHR_NUL) begin
				n.done = 1'b1;
			end else if (b == CHR_SPACE) begin
				n.found = 1'b1;
				n.at    = p;
				n.done  = 1'b1;
			end
		end
		return n;
	endfunction

	task automatic clear_parse_state;
		seen_cnt    = '0;
		seen_over   = 1'b0;
		head_word   = '0;
		head_method = METH_NONE;
		scan_any    = '{found: 1'b0, done: 1'b0, at: '0};
		scan_route  = '{found: 1'b0, done: 1'b0, at: '0};
	endtask

	// predictor: fold one accepted byte in, queue the route on the last byte
	task automatic track_request_byte(input logic [7:0] b, input logic l);
		logic [POS_W-1:0]   p;
		logic [ROUTE_W-1:0] last_pos;
		bit                 use_route;
		space_scan_t        pick;
		result_t            r;
		p = seen_cnt;
		if (p < MAX_LEN) begin
			if (p < 4) begin
				head_word = {head_word[23:0], b};
				if (p == 3)
					head_method = decode_head(head_word);
			end
			scan_any = scan_step(scan_any, b, p);
			if (p >= 4 && head_method != METH_NONE && p >= ROUTE_OFS[head_method])
				scan_route = scan_step(scan_route, b, p);
			seen_cnt = p + 1'b1;
		end else begin
			seen_over = 1'b1;
		end
		if (l) begin
			use_route     = (seen_cnt >= MIN_LEN) && (head_method != METH_NONE);
			pick          = use_route ? scan_route : scan_any;
			last_pos      = pick.at - 1'b1;
			r.method_code = (use_route && pick.found) ? head_method : METH_NONE;
			r.route_begin = use_route ? ROUTE_OFS[head_method] : '0;
			r.route_last  = pick.found ? last_pos : '0;
			r.route_found = pick.found;
			r.too_long    = seen_over;
			expected_routes.push_back(r);
			clear_parse_state();
		end
	endtask

	function automatic int pick_gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// send one request byte, called and returning at a rising edge
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		track_request_byte(b, l);
	endtask

	task automatic send_request(input octet_q_t q);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], i == q.size() - 1);
	endtask

	function automatic octet_q_t text_bytes(input string s);
		octet_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic string verb_text(input method_t m);
		case (m)
			METH_GET:    return "GET ";
			METH_POST:   return "POST ";
			METH_PUT:    return "PUT ";
			METH_PATCH:  return "PATCH ";
			METH_DELETE: return "DELETE ";
			default:     return "OPTIONS ";
		endcase
	endfunction

	// stop offering and let every queued route come out
	task automatic wait_all_results;
		s_tvalid <= 1'b0;
		while (expected_routes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_methods;
		send_request(text_bytes("GET /index.html HTTP/1.1"));
		// space right after the verb is skipped since the search starts at 5
		send_request(text_bytes("POST /api/v1 HTTP/1.1"));
		send_request(text_bytes("PUT /x HTTP/1.1xx"));
		send_request(text_bytes("PATCH /item/7 HTTP"));
		send_request(text_bytes("DELETE /item/9 HTTP"));
		send_request(text_bytes("OPTIONS * HTTP/1.1\r\n"));
		wait_all_results();
	endtask

	task automatic test_short_buffer;
		// 15 bytes: method ignored, search from 0
		send_request(text_bytes("GET /a HTTP/1.1"));
		send_request(text_bytes("GET /a HTTP/1.10"));
		send_request('{8'hFF});
		send_request('{8'h00});
		send_request('{CHR_SPACE});
		wait_all_results();
	endtask

	task automatic test_no_space;
		send_request(text_bytes("GET /abcdefghijklmn"));
		send_request(text_bytes("ABCDEFGHIJKLMNOPQ"));
		wait_all_results();
	endtask

	task automatic test_nul_stop;
		octet_q_t q;
		q = text_bytes("GET /ab");
		q.push_back(CHR_NUL);
		q = {q, text_bytes(" rest of line x")};
		send_request(q);
		q = '{CHR_NUL};
		q = {q, text_bytes(" spaces after nul")};
		send_request(q);
		wait_all_results();
	endtask

	task automatic test_unknown_method;
		send_request(text_bytes("HEAD /index HTTP/1.1"));
		// space at offset 0 gives a route end of minus one
		send_request(text_bytes(" hello world abcdef"));
		wait_all_results();
	endtask

	// long receiver stall while short requests keep coming
	task automatic test_receiver_hold;
		octet_q_t q;
		hold_req = 1'b1;
		wait (hold_active);
		steady = 1'b1;
		for (int k = 0; k < 6; k++) begin
			q = text_bytes(verb_text(method_t'($urandom_range(METH_GET, METH_OPTIONS))));
			while (q.size() < 10) q.push_back(8'($urandom_range(8'h21, 8'h7E)));
			q = {q, text_bytes(" HTTP/1.1")};
			send_request(q);
		end
		steady = 1'b0;
		wait_all_results();
	endtask

	task automatic test_random;
		octet_q_t q;
		int       sent;
		int       n;
		int       r;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			steady = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 99) < 70) begin
				// verb, route token, usually a space, random tail
				q = text_bytes(verb_text(method_t'($urandom_range(METH_GET, METH_OPTIONS))));
				if ($urandom_range(0, 9) == 0)
					q[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
				n = $urandom_range(0, 12);
				repeat (n) q.push_back(8'($urandom_range(8'h21, 8'h7E)));
				if ($urandom_range(0, 7) != 0)
					q.push_back(CHR_SPACE);
				n = $urandom_range(0, 20);
				repeat (n) q.push_back(8'($urandom_range(0, 255)));
			end else begin
				// noise heavy in spaces and nuls
				q = {};
				n = $urandom_range(1, 30);
				repeat (n) begin
					r = $urandom_range(0, 9);
					if (r < 2)
						q.push_back(CHR_SPACE);
					else if (r < 3)
						q.push_back(CHR_NUL);
					else
						q.push_back(8'($urandom_range(0, 255)));
				end
			end
			send_request(q);
			sent += q.size();
		end
		steady = 1'b0;
		wait_all_results();
	endtask

	// receiver: random stalls, or a long hold on request
	initial begin
		int r;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req) begin
				hold_req    = 1'b0;
				hold_active = 1'b1;
				m_tready   <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end else if (steady || r < 60) begin
				m_tready <= 1'b1;
				repeat (steady ? 1 : $urandom_range(1, 8)) @(posedge clk);
			end else if (r < 95) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	task automatic note_mismatch(input string field, input logic [ROUTE_W-1:0] want,
			input logic [ROUTE_W-1:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch %s: expected %0h got %0h", field, want, got);
	endtask

	// compare each route taken on the master side with the oldest prediction
	always @(negedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[$bits(result_t)-1:0]);
			if (expected_routes.size() == 0) begin
				note_mismatch("unexpected request", '0, ROUTE_W'(m_tdata));
			end else begin
				want = expected_routes.pop_front();
				if (got.method_code != want.method_code)
					note_mismatch("method_code", ROUTE_W'(want.method_code),
						ROUTE_W'(got.method_code));
				if (got.route_begin != want.route_begin)
					note_mismatch("route_begin", ROUTE_W'(want.route_begin),
						ROUTE_W'(got.route_begin));
				if (got.route_last != want.route_last)
					note_mismatch("route_last", want.route_last, got.route_last);
				if (got.route_found != want.route_found)
					note_mismatch("route_found", ROUTE_W'(want.route_found),
						ROUTE_W'(got.route_found));
				if (got.too_long != want.too_long)
					note_mismatch("too_long", ROUTE_W'(want.too_long),
						ROUTE_W'(got.too_long));
				if (m_tdata[OUT_W-1:$bits(result_t)] != '0)
					note_mismatch("padding", '0,
						ROUTE_W'(m_tdata[OUT_W-1:$bits(result_t)]));
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		clear_parse_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_methods();
		test_short_buffer();
		test_no_space();
		test_nul_stop();
		test_unknown_method();
		test_receiver_hold();
		test_random();
		repeat (10) @(posedge clk);
		if (expected_routes.size() != 0)
			note_mismatch("missing requests", '0, ROUTE_W'(expected_routes.size()));
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- http_method_route_parser.f -----
src/hmrp_pkg.sv
src/hmrp_in_stage.sv
src/hmrp_scan.sv
src/http_method_route_parser.sv
verif/tb.sv
